// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the product reduction block.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define APR_ASSERT_COMB(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Implication checked in the cycle after the trigger.
`define APR_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/apr_pkg.sv -----
// Shared types, constants and helpers of the column product reduction block.
// Depends on nothing.
package apr_pkg;

    localparam int APR_MAX_COLUMNS = 1024;
    localparam int X_W             = 32;
    localparam int COLUMN_COUNT_W  = 11;
    localparam int SAMPLE_COUNT_W  = 16;
    localparam int COLUMN_INDEX_W  = 10;
    localparam int CFG_DATA_W      = 16;
    localparam int OUT_TDATA_W     = 48;

    // Configuration register indexes.
    localparam logic CFG_COLUMN_COUNT = 1'b0;
    localparam logic CFG_SAMPLE_COUNT = 1'b1;

    localparam logic [31:0] F32_QUIET       = 32'h0040_0000;
    localparam logic [31:0] F32_DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] F32_INF_BITS    = 32'h7F80_0000;

    // Per-item classification decided by the front end.
    typedef struct packed {
        logic load;   // first row of a group: element becomes the product
        logic last;   // last row of a group: product leaves the block
        logic done;   // last column of the group
    } apr_tag_t;

    // Back end status seen by the top level.
    typedef struct packed {
        logic pop;
        logic hazard;
    } apr_back_stat_t;

    // Leading zeros of a 24-bit significand whose top bit is clear.
    function automatic logic [4:0] apr_lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd23;
        for (int i = 0; i < 24; i++)
        begin
            if (v[i])
            begin
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

endpackage

// ----- rtl/apr_front.sv -----
// Front end: configuration registers, row and column counters, item classification.
// Depends on apr_pkg.
module apr_front #(
    parameter int MAX_COLUMNS = apr_pkg::APR_MAX_COLUMNS,
    parameter int COL_W       = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_index,
    input  logic [apr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          push,
    output logic [COL_W-1:0]              item_col,
    output apr_pkg::apr_tag_t             item_tag
);
    import apr_pkg::*;

    localparam logic [16:0] MAXC = 17'(MAX_COLUMNS);

    logic [COL_W-1:0]          col_reg, col_next;
    logic [SAMPLE_COUNT_W-1:0] row_reg, row_next;
    logic [COLUMN_COUNT_W-1:0] column_count_reg, column_count_next;
    logic [SAMPLE_COUNT_W-1:0] sample_count_reg, sample_count_next;
    logic [16:0]               eff_cols;
    logic [SAMPLE_COUNT_W-1:0] eff_rows;
    logic                      last_col;
    logic                      last_row;

    // Effective sizes: zero counts as one, columns saturate at the memory depth.
    always_comb
    begin
        if (column_count_reg == '0)
            eff_cols = 17'd1;
        else if (17'(column_count_reg) > MAXC)
            eff_cols = MAXC;
        else
            eff_cols = 17'(column_count_reg);
        eff_rows = (sample_count_reg == '0) ? SAMPLE_COUNT_W'(1) : sample_count_reg;
    end

    assign last_col = (17'(col_reg) == eff_cols - 17'd1);
    assign last_row = (row_reg == eff_rows - SAMPLE_COUNT_W'(1));

    assign item_col      = col_reg;
    assign item_tag.load = (row_reg == '0);
    assign item_tag.last = last_row;
    assign item_tag.done = last_col;

    // Counter and register update; a register write restarts the group.
    always_comb
    begin
        col_next          = col_reg;
        row_next          = row_reg;
        column_count_next = column_count_reg;
        sample_count_next = sample_count_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_COLUMN_COUNT: column_count_next = cfg_data[COLUMN_COUNT_W-1:0];
                CFG_SAMPLE_COUNT: sample_count_next = cfg_data;
                default:          column_count_next = column_count_reg;
            endcase
            col_next = '0;
            row_next = '0;
        end
        else if (push)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + SAMPLE_COUNT_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg          <= '0;
            row_reg          <= '0;
            column_count_reg <= COLUMN_COUNT_W'(1);
            sample_count_reg <= SAMPLE_COUNT_W'(1);
        end
        else
        begin
            col_reg          <= col_next;
            row_reg          <= row_next;
            column_count_reg <= column_count_next;
            sample_count_reg <= sample_count_next;
        end
    end

endmodule

// ----- rtl/apr_fifo.sv -----
// Four-entry queue between the front end and the back end.
// Depends on nothing beyond its width parameter.
module apr_fifo #(
    parameter int DATA_W = 45
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic              head_valid,
    output logic [DATA_W-1:0] head_data,
    output logic              full
);
    logic [DATA_W-1:0] slot_reg [4];
    logic [1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [2:0]        count_reg, count_next;
    logic              do_push;

    assign full       = (count_reg == 3'd4);
    assign head_valid = (count_reg != 3'd0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !pop)
            count_next = count_reg + 3'd1;
        else if (!do_push && pop)
            count_next = count_reg - 3'd1;
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- rtl/apr_back.sv -----
// Back end: product memory, four-stage binary32 multiply and output register.
// Depends on apr_pkg.
module apr_back #(
    parameter int MAX_COLUMNS = apr_pkg::APR_MAX_COLUMNS,
    parameter int COL_W       = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  logic [apr_pkg::X_W-1:0]     head_x,
    input  logic [COL_W-1:0]            head_col,
    input  apr_pkg::apr_tag_t           head_tag,
    output apr_pkg::apr_back_stat_t     stat,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [31:0]                 out_product,
    output logic [COL_W-1:0]            out_col,
    output logic                        out_done
);
    import apr_pkg::*;

    logic [31:0] mem [MAX_COLUMNS];

    logic adv;
    logic hazard;
    logic pop;

    // Stage valid bits and per-stage side information.
    logic             s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [COL_W-1:0] s1_col_reg, s2_col_reg, s3_col_reg, s4_col_reg;
    apr_tag_t         s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg;

    logic [31:0] s1_x_reg, rd_reg;

    logic [23:0]       s2_ma_reg, s2_mb_reg;
    logic signed [9:0] s2_ea_reg, s2_eb_reg;
    logic              s2_sign_reg, s2_spec_reg;
    logic [31:0]       s2_spec_val_reg;

    logic [47:0]        s3_p_reg;
    logic signed [10:0] s3_e_reg;
    logic               s3_sign_reg, s3_spec_reg;
    logic [31:0]        s3_spec_val_reg;

    logic [31:0] s4_res_reg;

    logic        out_valid_reg;
    logic [31:0] out_product_reg;
    logic [COL_W-1:0] out_col_reg;
    logic        out_done_reg;

    // A row that reads a column waits while that column is still in the multiplier.
    assign hazard = head_valid && !head_tag.load &&
                    ((s1_valid_reg && s1_col_reg == head_col) ||
                     (s2_valid_reg && s2_col_reg == head_col) ||
                     (s3_valid_reg && s3_col_reg == head_col) ||
                     (s4_valid_reg && s4_col_reg == head_col));
    assign adv  = !out_valid_reg || out_ready;
    assign pop  = head_valid && adv && !hazard;
    assign stat.pop    = pop;
    assign stat.hazard = hazard;

    // Stage 2: unpack, special operands and subnormal normalization.
    logic [7:0]  a_exp, b_exp;
    logic [22:0] a_frac, b_frac;
    logic        a_nan, b_nan, a_zero, b_zero, a_inf_exp, b_inf_exp, p_sign;
    logic [4:0]  a_lz, b_lz;
    logic [23:0] a_man, b_man;
    logic signed [9:0] a_e, b_e;
    logic        spec;
    logic [31:0] spec_val;

    always_comb
    begin
        a_exp     = s1_x_reg[30:23];
        b_exp     = rd_reg[30:23];
        a_frac    = s1_x_reg[22:0];
        b_frac    = rd_reg[22:0];
        a_inf_exp = (a_exp == 8'hFF);
        b_inf_exp = (b_exp == 8'hFF);
        a_nan     = a_inf_exp && (a_frac != '0);
        b_nan     = b_inf_exp && (b_frac != '0);
        a_zero    = (s1_x_reg[30:0] == '0);
        b_zero    = (rd_reg[30:0] == '0);
        p_sign    = s1_x_reg[31] ^ rd_reg[31];
        a_lz      = apr_lzc24({1'b0, a_frac});
        b_lz      = apr_lzc24({1'b0, b_frac});
        if (a_exp == '0)
        begin
            a_man = {1'b0, a_frac} << a_lz;
            a_e   = 10'sd1 - signed'(10'(a_lz));
        end
        else
        begin
            a_man = {1'b1, a_frac};
            a_e   = signed'(10'(a_exp));
        end
        if (b_exp == '0)
        begin
            b_man = {1'b0, b_frac} << b_lz;
            b_e   = 10'sd1 - signed'(10'(b_lz));
        end
        else
        begin
            b_man = {1'b1, b_frac};
            b_e   = signed'(10'(b_exp));
        end
        spec     = 1'b1;
        spec_val = s1_x_reg;
        if (s1_tag_reg.load)
            spec_val = s1_x_reg;
        else if (a_nan)
            spec_val = s1_x_reg | F32_QUIET;
        else if (b_nan)
            spec_val = rd_reg | F32_QUIET;
        else if (a_inf_exp || b_inf_exp)
            spec_val = (a_zero || b_zero) ? F32_DEFAULT_NAN : ({p_sign, 31'b0} | F32_INF_BITS);
        else if (a_zero || b_zero)
            spec_val = {p_sign, 31'b0};
        else
            spec = 1'b0;
    end

    // Stage 4: normalize, round to nearest even, pack.
    logic [47:0]        pn;
    logic signed [10:0] en;
    logic signed [10:0] sh_full;
    logic [5:0]         sh;
    logic [63:0]        pp;
    logic [63:0]        m_full;
    logic               guard, sticky;
    logic [24:0]        mr;
    logic [32:0]        val;
    logic [31:0]        res;

    always_comb
    begin
        if (!s3_p_reg[47])
        begin
            pn = s3_p_reg << 1;
            en = s3_e_reg - 11'sd1;
        end
        else
        begin
            pn = s3_p_reg;
            en = s3_e_reg;
        end
        sh_full = 11'sd25 - en;
        if (en >= 11'sd1)
            sh = 6'd24;
        else if (sh_full > 11'sd60)
            sh = 6'd60;
        else
            sh = sh_full[5:0];
        pp     = {16'b0, pn};
        m_full = pp >> sh;
        guard  = pp[sh - 6'd1];
        sticky = |(pp & ((64'd1 << (sh - 6'd1)) - 64'd1));
        mr     = m_full[24:0] + 25'(guard && (sticky || m_full[0]));
        val    = {en[9:0] - 10'd1, 23'b0} + 33'(mr);
        // A subnormal that rounds up carries into the lowest exponent bit.
        if (en < 11'sd1)
            res = {s3_sign_reg, 7'b0, mr[23:0]};
        else if (val >= 33'(F32_INF_BITS))
            res = {s3_sign_reg, 31'b0} | F32_INF_BITS;
        else
            res = {s3_sign_reg, val[30:0]};
    end

    // Stage control bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pop;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg && s4_tag_reg.last;
        end
    end

    // Stage payload and memory access.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_reg          <= mem[head_col];
            s1_x_reg        <= head_x;
            s1_col_reg      <= head_col;
            s1_tag_reg      <= head_tag;

            s2_col_reg      <= s1_col_reg;
            s2_tag_reg      <= s1_tag_reg;
            s2_ma_reg       <= a_man;
            s2_mb_reg       <= b_man;
            s2_ea_reg       <= a_e;
            s2_eb_reg       <= b_e;
            s2_sign_reg     <= p_sign;
            s2_spec_reg     <= spec;
            s2_spec_val_reg <= spec_val;

            s3_col_reg      <= s2_col_reg;
            s3_tag_reg      <= s2_tag_reg;
            s3_p_reg        <= s2_ma_reg * s2_mb_reg;
            s3_e_reg        <= 11'(s2_ea_reg) + 11'(s2_eb_reg) - 11'sd126;
            s3_sign_reg     <= s2_sign_reg;
            s3_spec_reg     <= s2_spec_reg;
            s3_spec_val_reg <= s2_spec_val_reg;

            s4_col_reg      <= s3_col_reg;
            s4_tag_reg      <= s3_tag_reg;
            s4_res_reg      <= s3_spec_reg ? s3_spec_val_reg : res;

            out_product_reg <= s4_res_reg;
            out_col_reg     <= s4_col_reg;
            out_done_reg    <= s4_tag_reg.done;

            if (s4_valid_reg)
                mem[s4_col_reg] <= s4_res_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_product = out_product_reg;
    assign out_col     = out_col_reg;
    assign out_done    = out_done_reg;

endmodule

// ----- rtl/axis_product_reduce_f32.sv -----
// Top level of the column product reduction block: front end, queue, back end.
// Depends on apr_pkg, apr_front, apr_fifo, apr_back and assert_macros.svh.
`include "assert_macros.svh"

// Binary32 elements stream in row-major order; for every group of sample_count
// rows the block emits one product per column, each rounded to nearest even
// with subnormals kept. An item is taken every cycle while the output does
// not stall, as long as the column count is five or more; a column's next
// row must wait for its previous product to leave the four-stage multiply
// loop and return to the product memory, so with fewer than five columns
// items are not taken every cycle. First-row items never wait on their
// column. An item passes stages s1 to s4 and a last-row product then the
// output register. No clearing pass is needed after reset.
module axis_product_reduce_f32 #(
    parameter int MAX_COLUMNS = apr_pkg::APR_MAX_COLUMNS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [apr_pkg::X_W-1:0]        s_axis_tdata,   // [31:0] x_value
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [apr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [31:0] product_value,
                                                           // [41:32] column_index
    output logic                           m_axis_tlast,   // group_done
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [apr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import apr_pkg::*;

    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ITEM_W = X_W + COL_W + $bits(apr_tag_t);

    logic             push;
    logic [COL_W-1:0] front_col;
    apr_tag_t         front_tag;
    logic             fifo_full;
    logic             head_valid;
    logic [ITEM_W-1:0] head_data;
    logic [X_W-1:0]   head_x;
    logic [COL_W-1:0] head_col;
    apr_tag_t         head_tag;
    apr_back_stat_t   back_stat;
    logic [31:0]      out_product;
    logic [COL_W-1:0] out_col;
    logic [COLUMN_INDEX_W-1:0] out_index;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !fifo_full;
    assign push          = s_axis_tvalid && !fifo_full;

    // Classification of each incoming item.
    apr_front #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .COL_W      (COL_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .push     (push),
        .item_col (front_col),
        .item_tag (front_tag)
    );

    // Queue decoupling the two sides.
    apr_fifo #(
        .DATA_W(ITEM_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({s_axis_tdata, front_col, front_tag}),
        .pop       (back_stat.pop),
        .head_valid(head_valid),
        .head_data (head_data),
        .full      (fifo_full)
    );

    assign {head_x, head_col, head_tag} = head_data;

    // Multiply loop and product memory.
    apr_back #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .COL_W      (COL_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_x     (head_x),
        .head_col   (head_col),
        .head_tag   (head_tag),
        .stat       (back_stat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_product(out_product),
        .out_col    (out_col),
        .out_done   (m_axis_tlast)
    );

    // Column index is reported in its low ten bits.
    always_comb
    begin
        out_index = '0;
        out_index[((COL_W < COLUMN_INDEX_W) ? COL_W : COLUMN_INDEX_W)-1:0] =
            out_col[((COL_W < COLUMN_INDEX_W) ? COL_W : COLUMN_INDEX_W)-1:0];
    end

    assign m_axis_tdata = {6'b0, out_index, out_product};

    `APR_ASSERT_COMB(a_no_accept_when_full, fifo_full |-> !s_axis_tready)
    `APR_ASSERT_COMB(a_no_pop_on_hazard, back_stat.pop |-> !back_stat.hazard)
    `APR_ASSERT_COMB(a_pop_needs_item, back_stat.pop |-> head_valid)

endmodule

// ----- verif/tb_axis_product_reduce_f32.sv -----
// Testbench for the column product reduction block: drives binary32 rows in
// groups and checks every column product against its own binary32 multiplier.
// Depends on apr_pkg and the axis_product_reduce_f32 RTL.
`timescale 1ns / 1ps

module tb_axis_product_reduce_f32;
    import apr_pkg::*;

    localparam int COLS_MAX = APR_MAX_COLUMNS;

    typedef struct packed {
        logic [31:0] product;
        logic [9:0]  column;
        logic        done;
    } col_result_t;

    // One row of the directed table.
    typedef struct {
        logic [31:0] x;
        logic        known;
        logic [31:0] product;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [X_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor state.
    logic [31:0] pred_products [COLS_MAX];
    int unsigned pred_cols_reg;
    int unsigned pred_rows_reg;
    int unsigned pred_col;
    int unsigned pred_row;

    col_result_t pending_products [$];
    logic [31:0] typed_products [$];
    logic        typed_known [$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;

    axis_product_reduce_f32 dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Binary32 product, round to nearest even, subnormals kept; a is the element.
    function automatic logic [31:0] fmul32(input logic [31:0] a, input logic [31:0] b);
        logic        sgn;
        int          ea;
        int          eb;
        int          e;
        int          shift;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [63:0] p;
        logic [63:0] m;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] val;
        sgn = a[31] ^ b[31];
        ea = a[30:23];
        eb = b[30:23];
        ma = {1'b0, a[22:0]};
        mb = {1'b0, b[22:0]};
        if (ea == 255 && a[22:0] != 0)
            return a | F32_QUIET;
        if (eb == 255 && b[22:0] != 0)
            return b | F32_QUIET;
        if (ea == 255 || eb == 255)
        begin
            if (a[30:0] == 0 || b[30:0] == 0)
                return F32_DEFAULT_NAN;
            return {sgn, 31'h7F80_0000};
        end
        if (a[30:0] == 0 || b[30:0] == 0)
            return {sgn, 31'd0};
        if (ea == 0)
        begin
            ea = 1;
            while (!ma[23])
            begin
                ma = ma << 1;
                ea--;
            end
        end
        else
            ma[23] = 1'b1;
        if (eb == 0)
        begin
            eb = 1;
            while (!mb[23])
            begin
                mb = mb << 1;
                eb--;
            end
        end
        else
            mb[23] = 1'b1;
        p = 64'(ma) * 64'(mb);
        e = ea + eb - 126;
        if (!p[47])
        begin
            p = p << 1;
            e--;
        end
        shift = 24;
        if (e < 1)
        begin
            shift = 25 - e;
            if (shift > 60)
                shift = 60;
        end
        m = p >> shift;
        rem = p & ((64'd1 << shift) - 64'd1);
        half = 64'd1 << (shift - 1);
        if (rem > half || (rem == half && m[0]))
            m = m + 64'd1;
        if (e < 1)
            return {sgn, m[30:0]};
        val = (64'(e - 1) << 23) + m;
        if (val >= 64'h7F80_0000)
            return {sgn, 31'h7F80_0000};
        return {sgn, val[30:0]};
    endfunction

    // Advances the column predictor by one element; queues the product if any.
    task automatic predict_column_product(input logic [31:0] x);
        int unsigned cols;
        int unsigned rows;
        logic [31:0] acc;
        cols = (pred_cols_reg == 0) ? 1 : (pred_cols_reg > COLS_MAX ? COLS_MAX : pred_cols_reg);
        rows = (pred_rows_reg == 0) ? 1 : pred_rows_reg;
        if (pred_col >= cols)
            pred_col = 0;
        if (pred_row >= rows)
            pred_row = 0;
        acc = (pred_row == 0) ? x : fmul32(x, pred_products[pred_col]);
        pred_products[pred_col] = acc;
        if (pred_row == rows - 1)
            pending_products.push_back('{acc, pred_col[9:0], pred_col == cols - 1});
        pred_col++;
        if (pred_col >= cols)
        begin
            pred_col = 0;
            pred_row++;
            if (pred_row >= rows)
                pred_row = 0;
        end
    endtask

    // Sends one element, idling at random first; valid stays high between
    // back-to-back items and is dropped by the idle cycles or by a drain.
    task automatic send_element(input logic [31:0] x);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_column_product(x);
        @(negedge clk);
    endtask

    // Stops sending and waits until every product has come out, then long
    // enough for items that produce no product to leave the queue and the
    // multiply loop, even when each waits on its column.
    task automatic drain_products();
        s_axis_tvalid <= 1'b0;
        while (pending_products.size() != 0)
            @(negedge clk);
        repeat (40)
            @(negedge clk);
    endtask

    // Writes one register while the block is idle.
    task automatic write_reg(input logic idx, input logic [15:0] value);
        drain_products();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_COLUMN_COUNT)
            pred_cols_reg = value[10:0];
        else
            pred_rows_reg = value;
        pred_col = 0;
        pred_row = 0;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random binary32 pattern, biased toward specials and nearby exponents.
    function automatic logic [31:0] random_f32();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(9))
            0: v[30:23] = 8'hFF;
            1: v[30:23] = 8'h00;
            2: v[30:0] = 31'd0;
            3, 4, 5, 6: v[30:23] = 8'(127 + $signed($urandom_range(16)) - 8);
            default: ;
        endcase
        return v;
    endfunction

    // Output checker.
    always @(posedge clk)
    begin
        col_result_t got;
        col_result_t want;
        logic        known;
        logic [31:0] typed;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tdata[31:0], m_axis_tdata[41:32], m_axis_tlast};
            if (pending_products.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected product %h col %0d", got.product, got.column);
            end
            else
            begin
                want = pending_products.pop_front();
                known = 1'b0;
                typed = '0;
                if (typed_known.size() != 0)
                begin
                    known = typed_known.pop_front();
                    typed = typed_products.pop_front();
                end
                if (known && typed != want.product)
                    want.product = typed;
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("product mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 want.product, want.column, want.done,
                                 got.product, got.column, got.done);
                end
            end
        end
    end

    // Receiver: random stalls, with one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        dir_row_t    rows_tbl [$];
        logic [31:0] x;
        int          sent;
        int          phase;
        int          cols;
        int          nrows;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_COLUMN_COUNT;
        cfg_data = '0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 0;
        pred_cols_reg = 1;
        pred_rows_reg = 1;
        pred_col = 0;
        pred_row = 0;
        foreach (pred_products[i])
            pred_products[i] = '0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // After reset one row per group: each element comes back bit for bit.
        rows_tbl = '{'{32'h0000_0000, 1, 32'h0000_0000}, '{32'hFFFF_FFFF, 1, 32'hFFFF_FFFF},
                     '{32'h7F80_0001, 1, 32'h7F80_0001}, '{32'h8000_0001, 1, 32'h8000_0001},
                     '{32'h7F7F_FFFF, 1, 32'h7F7F_FFFF}, '{32'hAAAA_5555, 1, 32'hAAAA_5555},
                     '{32'h5555_AAAA, 1, 32'h5555_AAAA}};
        foreach (rows_tbl[i])
        begin
            typed_known.push_back(rows_tbl[i].known);
            typed_products.push_back(rows_tbl[i].product);
            send_element(rows_tbl[i].x);
        end
        drain_products();
        typed_known.delete();
        typed_products.delete();

        // One column, two rows: special products of the multiplier.
        write_reg(CFG_SAMPLE_COUNT, 16'd2);
        rows_tbl = '{'{32'h7F80_0000, 1, 32'hFFC0_0000}, '{32'h0000_0000, 0, 0},
                     '{32'h7F80_0001, 1, 32'h7FC0_0001}, '{32'h3F80_0000, 0, 0},
                     '{32'h3F80_0000, 1, 32'h7FC0_0002}, '{32'h7F80_0002, 0, 0},
                     '{32'h7F00_0000, 1, 32'h7F80_0000}, '{32'h7F00_0000, 0, 0},
                     '{32'h0080_0000, 1, 32'h0000_0000}, '{32'h0080_0000, 0, 0},
                     '{32'h0000_0001, 0, 0}, '{32'h3F00_0000, 0, 0},
                     '{32'h8040_0000, 0, 0}, '{32'h4000_0000, 0, 0}};
        foreach (rows_tbl[i])
        begin
            // Known results are tied to the last row of each pair.
            if (i % 2 == 1)
            begin
                typed_known.push_back(rows_tbl[i-1].known);
                typed_products.push_back(rows_tbl[i-1].product);
            end
            send_element(rows_tbl[i].x);
        end
        drain_products();
        typed_known.delete();
        typed_products.delete();

        // Zero counts fall back to one.
        write_reg(CFG_COLUMN_COUNT, 16'd0);
        write_reg(CFG_SAMPLE_COUNT, 16'd0);
        send_element(32'h1234_5678);
        send_element(32'hC000_0000);

        // Random phases over several shapes, including the extremes.
        sent = 0;
        phase = 0;
        while (sent < 1600)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 61; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 61; end
                default: begin send_idle_pct = 26; recv_idle_pct = 26; end
            endcase
            case (phase % 8)
                0: begin cols = 1;    nrows = 3; end
                1: begin cols = 2047; nrows = 1; end
                2: begin cols = $urandom_range(4, 1); nrows = $urandom_range(6, 2); end
                3: begin cols = 1024; nrows = 1; end
                4: begin cols = $urandom_range(40, 5); nrows = $urandom_range(4, 1); end
                5: begin cols = 3;    nrows = 65535; end
                6: begin cols = 1;    nrows = 0; end
                default: begin cols = $urandom_range(12, 1); nrows = $urandom_range(8, 1); end
            endcase
            write_reg(CFG_COLUMN_COUNT, 16'(cols));
            write_reg(CFG_SAMPLE_COUNT, 16'(nrows));
            if (phase == 2)
                hold_cycles = 300;
            repeat ((phase % 8 == 3) ? 1024 : ((phase % 8 == 5) ? 150 : 80))
            begin
                x = random_f32();
                send_element(x);
                sent++;
            end
            phase++;
        end
        drain_products();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (20)
            @(negedge clk);
        if (mismatches == 0 && pending_products.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
